@@ rtl/plb_pkg.sv @@
// shared types and codes for the price level book update block
package plb_pkg;

  localparam int QTY_W = 32;
  localparam int KEY_W = 41;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRADE  = 3'd4;

  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [ST_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [ST_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [QTY_W-1:0] value;
    logic             flag;  // carry on add, borrow on subtract
    logic             zero;
  } alu_res_t;

endpackage

@@ rtl/plb_alu.sv @@
// shared 32-bit quantity adder/subtractor with saturation and borrow flag
module plb_alu (
  input  plb_pkg::alu_op_t            op,
  input  logic [plb_pkg::QTY_W-1:0]   a,
  input  logic [plb_pkg::QTY_W-1:0]   b,
  output plb_pkg::alu_res_t           res
);
  import plb_pkg::*;

  logic             sub;
  logic [QTY_W:0]   b_ext;
  logic [QTY_W:0]   sum;

  assign sub   = (op == ALU_SUB);
  assign b_ext = sub ? ~{1'b0, b} : {1'b0, b};
  // top bit is the carry for add and the borrow for subtract
  assign sum   = {1'b0, a} + b_ext + {{QTY_W{1'b0}}, sub};

  always_comb begin
    res.flag  = sum[QTY_W];
    res.value = (!sub && sum[QTY_W]) ? {QTY_W{1'b1}} : sum[QTY_W-1:0];
    res.zero  = (res.value == '0);
  end

endmodule

@@ rtl/price_level_book_update_top.sv @@
// price level book: aggregated quantity per symbol, side and price, updated by order events
//
// Each request takes one order event and yields exactly one response. The level table is a
// memory with one read port and one write port, scanned one entry per cycle to find the
// matching key and the lowest free entry. A request passes through quantity preparation
// (S_PREP for modify and delete, then S_PREP2 for a modify that raises the quantity), the
// search (S_SCAN, which stops early when the level is found), the update (S_APPLY) and
// S_OUT, which presents the response. Events with an unknown command or symbol are
// answered in the cycle after the request; the next request can be accepted in the cycle
// after the response is taken. One shared adder/subtractor does all quantity arithmetic in
// turn. After reset every table entry is cleared before the first request is taken.
// in_tready is high only while the block is idle and no response is waiting.
module price_level_book_update_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int NUM_SYMBOLS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // symbol_index[7:0], side[8], price[40:9], order_quantity[72:41],
  // filled_qty[104:73], cancel_qty[136:105],
  // executed_quantity[168:137], new_quantity[200:169], zero fill [207:201]
  input  logic [207:0]               in_tdata,
  // command[2:0]
  input  logic [plb_pkg::CMD_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // level_quantity[31:0]
  output logic [plb_pkg::QTY_W-1:0]  out_tdata,
  // status[2:0]
  output logic [plb_pkg::ST_W-1:0]   out_tuser
);
  import plb_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = AW + 1;
  localparam int ENTRY_W = 1 + KEY_W + QTY_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_PREP2,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AW-1:0]     chk_idx_r;
  logic              data_ok_r;
  logic              match_r;
  logic [AW-1:0]     match_idx_r;
  logic              free_ok_r;
  logic [AW-1:0]     free_idx_r;
  logic              grow_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [QTY_W-1:0]  oq_r;
  logic [QTY_W-1:0]  fq_r;
  logic [QTY_W-1:0]  nq_r;
  logic [QTY_W-1:0]  delta_r;
  logic [QTY_W-1:0]  total_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [QTY_W-1:0]  out_qty_r;

  // table memory: {valid, key, total}
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] mem_q_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // unpacked input fields
  logic [7:0]        in_sym;
  logic [KEY_W-1:0]  in_key;
  logic [QTY_W-1:0]  in_oq, in_fq, in_cq, in_eq, in_nq;
  logic              in_bad;

  alu_op_t           alu_op;
  logic [QTY_W-1:0]  alu_a, alu_b;
  alu_res_t          alu_res;

  logic              q_valid;
  logic [KEY_W-1:0]  q_key;
  logic              hit;

  assign in_sym = in_tdata[7:0];
  assign in_key = {in_tdata[7:0], in_tdata[8], in_tdata[40:9]};
  assign in_oq  = in_tdata[72:41];
  assign in_fq  = in_tdata[104:73];
  assign in_cq  = in_tdata[136:105];
  assign in_eq  = in_tdata[168:137];
  assign in_nq  = in_tdata[200:169];
  assign in_bad = (in_tuser > CMD_TRADE) || ({24'd0, in_sym} >= 32'(NUM_SYMBOLS));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_qty_r;
  assign out_tuser  = out_status_r;

  assign q_valid = mem_q_r[ENTRY_W-1];
  assign q_key   = mem_q_r[ENTRY_W-2 -: KEY_W];
  assign hit     = data_ok_r && q_valid && (q_key == key_r);

  plb_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = oq_r;
    alu_b  = fq_r;
    unique case (state_r)
      S_PREP: begin
        alu_b = (cmd_r == CMD_MODIFY) ? nq_r : fq_r;
      end
      S_PREP2: begin
        alu_a = nq_r;
        alu_b = oq_r;
      end
      S_APPLY: begin
        alu_op = grow_r ? ALU_ADD_SAT : ALU_SUB;
        alu_a  = total_r;
        alu_b  = delta_r;
      end
      default: begin
      end
    endcase
  end

  // table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_APPLY: begin
        if (match_r) begin
          mem_we    = 1'b1;
          mem_waddr = match_idx_r;
          if (!grow_r && (alu_res.flag || alu_res.zero)) begin
            mem_wdata = '0;
          end else begin
            mem_wdata = {1'b1, key_r, alu_res.value};
          end
        end else if (grow_r && free_ok_r) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = {1'b1, key_r, delta_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      data_ok_r    <= 1'b0;
      match_r      <= 1'b0;
      free_ok_r    <= 1'b0;
      grow_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_IGNORED;
      out_qty_r    <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r[AW-1:0] == AW'(TABLE_DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= in_tuser;
            key_r     <= in_key;
            oq_r      <= in_oq;
            fq_r      <= in_fq;
            nq_r      <= in_nq;
            cnt_r     <= '0;
            data_ok_r <= 1'b0;
            match_r   <= 1'b0;
            free_ok_r <= 1'b0;
            if (in_bad) begin
              out_status_r <= ST_IGNORED;
              out_qty_r    <= '0;
              out_valid_r  <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              unique case (in_tuser)
                CMD_ADD: begin
                  delta_r <= in_oq;
                  grow_r  <= 1'b1;
                  state_r <= S_SCAN;
                end
                CMD_CANCEL: begin
                  delta_r <= in_cq;
                  grow_r  <= 1'b0;
                  state_r <= S_SCAN;
                end
                CMD_TRADE: begin
                  delta_r <= in_eq;
                  grow_r  <= 1'b0;
                  state_r <= S_SCAN;
                end
                default: begin
                  grow_r  <= 1'b0;
                  state_r <= S_PREP;
                end
              endcase
            end
          end
        end
        S_PREP: begin
          if (cmd_r == CMD_MODIFY) begin
            if (alu_res.flag) begin
              // new quantity above old: the difference is added instead
              grow_r  <= 1'b1;
              state_r <= S_PREP2;
            end else begin
              delta_r <= alu_res.value;
              state_r <= S_SCAN;
            end
          end else begin
            // remaining quantity clamped at zero
            delta_r <= alu_res.flag ? '0 : alu_res.value;
            state_r <= S_SCAN;
          end
        end
        S_PREP2: begin
          delta_r <= alu_res.value;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            match_r     <= 1'b1;
            match_idx_r <= chk_idx_r;
            total_r     <= mem_q_r[QTY_W-1:0];
            state_r     <= S_APPLY;
          end else begin
            if (data_ok_r && !q_valid && !free_ok_r) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
            if (cnt_r != CNT_W'(TABLE_DEPTH)) begin
              chk_idx_r <= cnt_r[AW-1:0];
              data_ok_r <= 1'b1;
              cnt_r     <= cnt_r + 1'b1;
            end else begin
              data_ok_r <= 1'b0;
              if (!data_ok_r) begin
                state_r <= S_APPLY;
              end
            end
          end
        end
        S_APPLY: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
          if (match_r) begin
            if (!grow_r && (alu_res.flag || alu_res.zero)) begin
              out_status_r <= ST_REMOVED;
              out_qty_r    <= '0;
            end else begin
              out_status_r <= ST_UPDATED;
              out_qty_r    <= alu_res.value;
            end
          end else if (grow_r) begin
            if (free_ok_r) begin
              out_status_r <= ST_INSERTED;
              out_qty_r    <= delta_r;
            end else begin
              out_status_r <= ST_FULL;
              out_qty_r    <= '0;
            end
          end else begin
            out_status_r <= ST_IGNORED;
            out_qty_r    <= '0;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            cnt_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a waiting response blocks new requests
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request accepted while a response is pending");

  // removed, refused and ignored events report zero quantity
  a_zero_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_REMOVED || out_tuser == ST_FULL ||
                    out_tuser == ST_IGNORED)) |-> (out_tdata == '0))
    else $error("nonzero quantity on removed or ignored response");

  // the table is never written while it is being searched
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("table write during search");

  // a response appears only after a request was taken
  a_resp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (state_r == S_OUT && $past(state_r != S_OUT)))
    else $error("response raised outside the output state");

endmodule

@@ bench/tb.sv @@
// self-checking bench for the price level book: order events in, level status and total out
module tb;
  import plb_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int NUM_SYMBOLS = 256;
  localparam int POOL_SIZE   = 16;
  localparam int MAX_GAP     = 300;
  localparam int MAX_STALL   = 250;
  localparam int CMD_LAST    = (1 << CMD_W) - 1;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       sym;
    logic             side;
    logic [31:0]      price;
    logic [QTY_W-1:0] oq;
    logic [QTY_W-1:0] fq;
    logic [QTY_W-1:0] cq;
    logic [QTY_W-1:0] eq;
    logic [QTY_W-1:0] nq;
  } order_evt_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [QTY_W-1:0] qty;
  } level_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [207:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [QTY_W-1:0] out_tdata;
  logic [ST_W-1:0] out_tuser;

  order_evt_t pending_events[$];
  level_result_t expected_levels[$];

  // shadow copy of the level table
  logic             lvl_valid [TABLE_DEPTH];
  logic [KEY_W-1:0] lvl_key   [TABLE_DEPTH];
  logic [QTY_W-1:0] lvl_total [TABLE_DEPTH];

  int fail_count = 0;
  int cycle_count = 0;
  int cycle_limit = 32'h7fff_ffff;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cnt = 0;
  logic rx_ready_phase = 1'b0;

  logic [7:0]  pool_sym   [POOL_SIZE];
  logic        pool_side  [POOL_SIZE];
  logic [31:0] pool_price [POOL_SIZE];

  price_level_book_update_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic level_result_t book_insert(input logic [KEY_W-1:0] key,
                                                input logic [QTY_W-1:0] qty);
    level_result_t r;
    r.status = ST_FULL;
    r.qty = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!lvl_valid[i]) begin
        lvl_valid[i] = 1'b1;
        lvl_key[i] = key;
        lvl_total[i] = qty;
        r.status = ST_INSERTED;
        r.qty = qty;
        return r;
      end
    end
    return r;
  endfunction

  // a level that would reach zero or below is dropped
  function automatic level_result_t book_reduce(input int idx, input logic [QTY_W-1:0] dec);
    level_result_t r;
    if (lvl_total[idx] <= dec) begin
      lvl_valid[idx] = 1'b0;
      r.status = ST_REMOVED;
      r.qty = '0;
    end else begin
      lvl_total[idx] = lvl_total[idx] - dec;
      r.status = ST_UPDATED;
      r.qty = lvl_total[idx];
    end
    return r;
  endfunction

  function automatic level_result_t book_apply(input order_evt_t e);
    level_result_t r;
    logic [KEY_W-1:0] key;
    logic [QTY_W:0] sum;
    int hit;
    r.status = ST_IGNORED;
    r.qty = '0;
    if (e.cmd > CMD_TRADE || e.sym >= NUM_SYMBOLS) return r;
    key = {e.sym, e.side, e.price};
    hit = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
      if (lvl_valid[i] && lvl_key[i] == key) hit = i;
    case (e.cmd)
      CMD_ADD: begin
        if (hit < 0) begin
          r = book_insert(key, e.oq);
        end else begin
          sum = lvl_total[hit] + e.oq;
          lvl_total[hit] = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
          r.status = ST_UPDATED;
          r.qty = lvl_total[hit];
        end
      end
      CMD_MODIFY: begin
        if (e.nq > e.oq) begin
          if (hit < 0) begin
            r = book_insert(key, e.nq - e.oq);
          end else begin
            // a positive raise never brings the level down to zero
            sum = lvl_total[hit] + (e.nq - e.oq);
            lvl_total[hit] = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
            r.status = ST_UPDATED;
            r.qty = lvl_total[hit];
          end
        end else if (hit >= 0) begin
          r = book_reduce(hit, e.oq - e.nq);
        end
      end
      CMD_CANCEL: if (hit >= 0) r = book_reduce(hit, e.cq);
      CMD_DELETE: if (hit >= 0) r = book_reduce(hit, e.oq > e.fq ? e.oq - e.fq : '0);
      CMD_TRADE:  if (hit >= 0) r = book_reduce(hit, e.eq);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [QTY_W-1:0] rand_qty();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom();
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  // any code past trade is treated as unknown
  function automatic logic [CMD_W-1:0] rand_bad_cmd();
    return CMD_W'($urandom_range(CMD_TRADE + 1, CMD_LAST));
  endfunction

  task automatic push_evt(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                          input logic side, input logic [31:0] price,
                          input logic [QTY_W-1:0] oq, input logic [QTY_W-1:0] fq,
                          input logic [QTY_W-1:0] cq, input logic [QTY_W-1:0] eq,
                          input logic [QTY_W-1:0] nq);
    order_evt_t e;
    e.cmd = cmd;
    e.sym = sym;
    e.side = side;
    e.price = price;
    e.oq = oq;
    e.fq = fq;
    e.cq = cq;
    e.eq = eq;
    e.nq = nq;
    pending_events.push_back(e);
  endtask

  task automatic push_random(input int count);
    int pick;
    int p;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_ADD;
      else if (pick < 50) cmd = CMD_MODIFY;
      else if (pick < 65) cmd = CMD_CANCEL;
      else if (pick < 80) cmd = CMD_DELETE;
      else if (pick < 95) cmd = CMD_TRADE;
      else cmd = rand_bad_cmd();
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        push_evt(cmd, pool_sym[p], pool_side[p], pool_price[p], rand_qty(), rand_qty(),
                 rand_qty(), rand_qty(), rand_qty());
      end else begin
        push_evt(cmd, 8'($urandom()), 1'($urandom()), $urandom(), rand_qty(), rand_qty(),
                 rand_qty(), rand_qty(), rand_qty());
      end
    end
  endtask

  // request driver: bursts of back-to-back events with random gaps between them
  always @(posedge clk) begin
    order_evt_t e;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_events.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          e = pending_events.pop_front();
          in_tuser <= e.cmd;
          in_tdata <= {7'b0, e.nq, e.eq, e.cq, e.fq, e.oq, e.price, e.side, e.sym};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, MAX_GAP)
                                                   : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // response side alternates ready runs and stall runs
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else begin
      rx_ready_phase = !rx_ready_phase;
      if (rx_ready_phase) hold_cnt = $urandom_range(0, 80);
      else if ($urandom_range(0, 9) == 0) hold_cnt = $urandom_range(30, MAX_STALL);
      else hold_cnt = $urandom_range(0, 5);
    end
    out_tready <= rx_ready_phase;
  end

  // predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    order_evt_t e;
    level_result_t want;
    cycle_count++;
    if (rst_n) begin
      if (in_tvalid && in_tready === 1'b1) begin
        e.cmd = in_tuser;
        e.sym = in_tdata[7:0];
        e.side = in_tdata[8];
        e.price = in_tdata[40:9];
        e.oq = in_tdata[72:41];
        e.fq = in_tdata[104:73];
        e.cq = in_tdata[136:105];
        e.eq = in_tdata[168:137];
        e.nq = in_tdata[200:169];
        expected_levels.push_back(book_apply(e));
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status %0d qty %0d",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata !== want.qty) begin
            $display("%0t: level quantity mismatch, expected %0d actual %0d",
                     $time, want.qty, out_tdata);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= cycle_limit);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lvl_valid[i] = 1'b0;
      lvl_key[i] = '0;
      lvl_total[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_sym[i] = 8'($urandom());
      pool_side[i] = 1'($urandom());
      pool_price[i] = $urandom();
    end

    // directed: saturation, zero levels, clamped delete, misses, unknown codes
    push_evt(CMD_ADD, 8'd3, 1'b0, 32'd1000, 32'd100, '0, '0, '0, '0);
    push_evt(CMD_ADD, 8'd3, 1'b0, 32'd1000, '1, '1, '1, '1, '1);
    push_evt(CMD_MODIFY, 8'd3, 1'b0, 32'd1000, '0, '0, '0, '0, 32'd5);
    push_evt(CMD_CANCEL, 8'd3, 1'b0, 32'd1000, '0, '0, '1, '0, '0);
    push_evt(CMD_ADD, 8'd3, 1'b0, 32'd1000, '0, '0, '0, '0, '0);
    push_evt(CMD_TRADE, 8'd3, 1'b0, 32'd1000, '1, '1, '1, '0, '1);
    push_evt(CMD_ADD, 8'hff, 1'b1, '1, 32'd50, '0, '0, '0, '0);
    push_evt(CMD_ADD, 8'hff, 1'b0, '1, 32'd9, '0, '0, '0, '0);
    push_evt(CMD_CANCEL, 8'hff, 1'b1, '1, '0, '0, '0, '0, '0);
    push_evt(CMD_DELETE, 8'hff, 1'b1, '1, 32'd10, 32'd30, '0, '0, '0);
    push_evt(CMD_DELETE, 8'hff, 1'b1, '1, 32'd30, 32'd10, '0, '0, '0);
    push_evt(CMD_MODIFY, 8'hff, 1'b1, '1, 32'd40, '0, '0, '0, 32'd15);
    push_evt(CMD_MODIFY, 8'hff, 1'b1, '1, 32'd7, '0, '0, '0, 32'd7);
    push_evt(CMD_TRADE, 8'hff, 1'b1, '1, '0, '0, '0, 32'd5, '0);
    push_evt(CMD_CANCEL, 8'hff, 1'b1, '1, '0, '0, 32'd1, '0, '0);
    push_evt(CMD_DELETE, 8'hff, 1'b1, '1, 32'd8, 32'd1, '0, '0, '0);
    push_evt(CMD_TRADE, 8'hff, 1'b1, '1, '0, '0, '0, 32'd1, '0);
    push_evt(CMD_MODIFY, 8'd77, 1'b1, 32'd500, 32'd20, '0, '0, '0, 32'd20);
    push_evt(CMD_MODIFY, 8'd77, 1'b1, 32'd500, 32'd20, '0, '0, '0, 32'd3);
    push_evt(CMD_MODIFY, 8'd77, 1'b1, 32'd500, '0, '0, '0, '0, '1);
    push_evt(CMD_ADD, 8'd0, 1'b0, 32'd0, '1, '1, '1, '1, '1);
    for (int c = CMD_TRADE + 1; c <= CMD_LAST; c++)
      push_evt(CMD_W'(c), 8'd0, 1'b0, 32'd0, '1, '1, '1, '1, '1);

    push_random(800);

    // fill the table with distinct levels until inserts are refused
    for (int i = 0; i < 280; i++)
      push_evt(CMD_ADD, i[7:0], i[8], 32'hf000_0000 | i, rand_qty(), rand_qty(),
               rand_qty(), rand_qty(), rand_qty());
    for (int i = 0; i < 10; i++)
      push_evt(CMD_ADD, i[7:0], 1'b1, 32'he000_0000 | i, rand_qty(), rand_qty(),
               rand_qty(), rand_qty(), rand_qty());
    for (int i = 0; i < 5; i++)
      push_evt(CMD_MODIFY, i[7:0], 1'b0, 32'he000_0000 | i, 32'd1, rand_qty(),
               rand_qty(), rand_qty(), 32'd900);
    for (int i = 0; i < 5; i++)
      push_evt(CMD_ADD, i[7:0], i[8], 32'hf000_0000 | i, rand_qty(), rand_qty(),
               rand_qty(), rand_qty(), rand_qty());
    for (int i = 0; i < 280; i++)
      push_evt(CMD_CANCEL, i[7:0], i[8], 32'hf000_0000 | i, rand_qty(), rand_qty(),
               '1, rand_qty(), rand_qty());

    push_random(400);

    cycle_limit = 4 * pending_events.size() * (TABLE_DEPTH + 8 + MAX_GAP + MAX_STALL)
                  + 4 * TABLE_DEPTH + 1000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_events.size() != 0 || in_tvalid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
